### rtl/core/segment_quad_intersection_macros.svh
// ----------------------------------------------------------------------------
// Segment/quad intersection assertion macros
// Shared concurrent assertion helpers, clocked on clk with synchronous rst_n.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_QUAD_INTERSECTION_MACROS_SVH
`define SEGMENT_QUAD_INTERSECTION_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define SQI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sqi assertion failed");
// Next-cycle implication.
`define SQI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sqi assertion failed");
`else
`define SQI_ASSERT_NOW(lbl, ante, cons)
`define SQI_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### rtl/core/sqi_pkg.sv
// ----------------------------------------------------------------------------
// Segment/quad intersection package
// Fixed stream layout and pipeline latency constants.
// ----------------------------------------------------------------------------
package sqi_pkg;

  localparam int FIELD_W       = 63;  // one packed x,y,z point
  localparam int NUM_IN_FIELDS = 6;
  localparam int IN_TDATA_W    = 384;
  localparam int OUT_TDATA_W   = 64;
  localparam int OUT_COORD_W   = 21;
  localparam int OUT_HIT_BIT   = 0;
  localparam int TRI_LAT       = 5;   // stages inside one triangle test
  localparam int DIV_RND_LAT   = 1;   // rounding stage after the divider steps

endpackage

### rtl/core/sqi_tri.sv
// ----------------------------------------------------------------------------
// Triangle test pipeline
// Five-stage Moller-Trumbore test: cross products, dot products, sums,
// orientation fix, and the barycentric and range checks.
// ----------------------------------------------------------------------------
module sqi_tri
  import sqi_pkg::*;
#(
  parameter int DW = 22,
  parameter int XW = 45,
  parameter int PW = 69,
  parameter int NW = 70,
  parameter logic [NW-1:0] THR = 1
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [DW-1:0] e1   [3],
  input  logic signed [DW-1:0] e2   [3],
  input  logic signed [DW-1:0] dir  [3],
  input  logic signed [DW-1:0] sv   [3],
  output logic                 ok,
  output logic        [NW-1:0] t_o,
  output logic        [NW-1:0] adet_o
);

  localparam int MW = DW + XW;

  // Stage 1: q = dir x e2, r = sv x e1.
  logic signed [XW-1:0] q_r [3], r_r [3];
  logic signed [DW-1:0] e1_r [3], e2_r [3], dir_r [3], sv_r [3];

  for (genvar g = 0; g < 3; g++) begin : g_cross
    localparam int I1 = (g + 1) % 3;
    localparam int I2 = (g + 2) % 3;
    logic signed [2*DW-1:0] qa, qb, ra, rb;
    assign qa = dir[I1] * e2[I2];
    assign qb = dir[I2] * e2[I1];
    assign ra = sv[I1] * e1[I2];
    assign rb = sv[I2] * e1[I1];
    always_ff @(posedge clk) begin
      if (en) begin
        q_r[g]   <= XW'(qa) - XW'(qb);
        r_r[g]   <= XW'(ra) - XW'(rb);
        e1_r[g]  <= e1[g];
        e2_r[g]  <= e2[g];
        dir_r[g] <= dir[g];
        sv_r[g]  <= sv[g];
      end
    end
  end

  // Stage 2: the twelve dot-product terms.
  logic signed [MW-1:0] pd_r [3], pu_r [3], pv_r [3], pt_r [3];

  for (genvar g = 0; g < 3; g++) begin : g_dot
    logic signed [MW-1:0] pd, pu, pv, pt;
    assign pd = e1_r[g] * q_r[g];
    assign pu = sv_r[g] * q_r[g];
    assign pv = dir_r[g] * r_r[g];
    assign pt = e2_r[g] * r_r[g];
    always_ff @(posedge clk) begin
      if (en) begin
        pd_r[g] <= pd;
        pu_r[g] <= pu;
        pv_r[g] <= pv;
        pt_r[g] <= pt;
      end
    end
  end

  // Stage 3: det, u, v, t.
  logic signed [PW-1:0] det_r, u_r, v_r, t_r;

  always_ff @(posedge clk) begin
    if (en) begin
      det_r <= PW'(pd_r[0]) + PW'(pd_r[1]) + PW'(pd_r[2]);
      u_r   <= PW'(pu_r[0]) + PW'(pu_r[1]) + PW'(pu_r[2]);
      v_r   <= PW'(pv_r[0]) + PW'(pv_r[1]) + PW'(pv_r[2]);
      t_r   <= PW'(pt_r[0]) + PW'(pt_r[1]) + PW'(pt_r[2]);
    end
  end

  // Stage 4: fold the sign of det into u, v, t.
  logic                 neg;
  logic signed [NW-1:0] det_w, u_w, v_w, t_w;
  logic        [NW-1:0] adet_nxt;
  logic        [NW-1:0] adet4_r;
  logic signed [NW-1:0] u4_r, v4_r, t4_r;
  logic                 deg4_r;

  always_comb begin
    neg      = det_r[PW-1];
    det_w    = NW'(det_r);
    u_w      = NW'(u_r);
    v_w      = NW'(v_r);
    t_w      = NW'(t_r);
    adet_nxt = neg ? NW'(-det_w) : NW'(det_w);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      adet4_r <= adet_nxt;
      u4_r    <= neg ? -u_w : u_w;
      v4_r    <= neg ? -v_w : v_w;
      t4_r    <= neg ? -t_w : t_w;
      deg4_r  <= adet_nxt < THR;
    end
  end

  // Stage 5: barycentric and segment-range checks.
  logic [NW:0] uv;
  logic        ok_nxt;
  logic        ok_r;
  logic [NW-1:0] t5_r, adet5_r;

  always_comb begin
    uv     = {1'b0, u4_r} + {1'b0, v4_r};
    ok_nxt = !deg4_r && !u4_r[NW-1] && !v4_r[NW-1] && !t4_r[NW-1] &&
             !({1'b0, adet4_r} < uv) && !(adet4_r < NW'(t4_r));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok_r    <= ok_nxt;
      t5_r    <= NW'(t4_r);
      adet5_r <= adet4_r;
    end
  end

  assign ok     = ok_r;
  assign t_o    = t5_r;
  assign adet_o = adet5_r;

endmodule

### rtl/core/sqi_div.sv
// ----------------------------------------------------------------------------
// Scaled divider pipeline
// Computes round(m * t / den) for t <= den, one bit of m per stage, then a
// rounding stage (ties away from zero on the magnitude).
// ----------------------------------------------------------------------------
module sqi_div
  import sqi_pkg::*;
#(
  parameter int MW = 21,
  parameter int NW = 70
) (
  input  logic          clk,
  input  logic          en,
  input  logic [MW-1:0] m,
  input  logic [NW-1:0] t,
  input  logic [NW-1:0] den,
  output logic [MW:0]   q
);

  localparam int XW = NW + 2;

  logic [NW-1:0] rem_r [MW];
  logic [MW:0]   q_r   [MW];
  logic [MW-1:0] m_r   [MW];
  logic [NW-1:0] t_r   [MW];
  logic [NW-1:0] den_r [MW];

  for (genvar g = 0; g < MW; g++) begin : g_step
    logic [NW-1:0] rem_in, t_in, den_in;
    logic [MW-1:0] m_in;
    logic [MW:0]   q_in;
    logic [XW-1:0] x, x1, x2, d1, d2;
    logic          ge1, ge2;

    if (g == 0) begin : g_first
      assign rem_in = '0;
      assign q_in   = '0;
      assign m_in   = m;
      assign t_in   = t;
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_r[g-1];
      assign q_in   = q_r[g-1];
      assign m_in   = m_r[g-1];
      assign t_in   = t_r[g-1];
      assign den_in = den_r[g-1];
    end

    // Remainder stays below den, so the partial sum stays below 3*den.
    always_comb begin
      d1  = XW'(den_in);
      d2  = XW'({den_in, 1'b0});
      x   = XW'({rem_in, 1'b0}) + (m_in[MW-1-g] ? XW'(t_in) : '0);
      x1  = x - d1;
      x2  = x - d2;
      ge1 = x >= d1;
      ge2 = x >= d2;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g] <= ge2 ? NW'(x2) : (ge1 ? NW'(x1) : NW'(x));
        q_r[g]   <= {q_in[MW-1:0], 1'b0} + (ge2 ? (MW+1)'(2) : (ge1 ? (MW+1)'(1) : '0));
        m_r[g]   <= m_in;
        t_r[g]   <= t_in;
        den_r[g] <= den_in;
      end
    end
  end

  logic [MW:0] q_out_r;
  logic        up;

  assign up = {rem_r[MW-1], 1'b0} >= {1'b0, den_r[MW-1]};

  always_ff @(posedge clk) begin
    if (en) begin
      q_out_r <= q_r[MW-1] + (MW+1)'(up);
    end
  end

  assign q = q_out_r;

endmodule

### rtl/core/segment_quad_intersection.sv
// ----------------------------------------------------------------------------
// Segment versus quad intersection
// Streaming fixed-point Moller-Trumbore test of a segment against a quad.
// ----------------------------------------------------------------------------
// One request carries a segment and a planar quad a,b,c,d; the quad is tested
// as triangles (a,b,c) and (a,c,d), and the first one crossed gives the point
// s0 + d*t/|det|, rounded and clamped, or zero with hit low. The block takes a
// new request every cycle while the pipeline is not held. From acceptance to the
// result register a request passes one difference stage, five stages of triangle
// test (both triangles side by side), one select stage, COORD_BITS restoring
// divider steps (one bit of |d| per stage) plus a rounding stage, and the output
// register. A result waiting at the output does not block intake until the last
// pipeline stage also holds an item; then the whole pipeline holds.
`include "segment_quad_intersection_macros.svh"

module segment_quad_intersection
  import sqi_pkg::*;
#(
  parameter int COORD_BITS = 21,
  parameter int FRAC_BITS  = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // seg_start, seg_end, corner_a, corner_b, corner_c, corner_d (63 bits each),
  // zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // hit (1), point_x (21), point_y (21), point_z (21)
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int CW  = COORD_BITS;
  localparam int DW  = CW + 1;         // coordinate differences
  localparam int XW  = 2 * DW + 1;     // cross products
  localparam int PW  = 3 * DW + 3;     // det, u, v, t
  localparam int NW  = PW + 1;         // after sign folding
  localparam int TSH = 3 * FRAC_BITS - 16;
  localparam logic [NW-1:0] THR = (TSH > 0) ? (NW'(1) << TSH) : NW'(1);
  localparam int DL  = CW + DIV_RND_LAT;
  localparam int L   = 1 + TRI_LAT + 1 + DL;

  // Pipeline control: hold only when the last stage and the output are both full.
  logic         en;
  logic [L-1:0] vld_r;
  logic         out_valid_r;
  logic         out_load;

  assign en        = !vld_r[L-1] || !out_valid_r || out_tready;
  assign in_tready = en;
  assign out_load  = vld_r[L-1] && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (en) begin
        vld_r <= {vld_r[L-2:0], in_tvalid};
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Stage A: unpack and form edges, direction and s0 - a.
  logic signed [CW-1:0] pt [NUM_IN_FIELDS][3];
  logic signed [CW-1:0] s0_a [3];
  logic signed [DW-1:0] dir_a [3], sv_a [3], eb_a [3], ec_a [3], ed_a [3];

  for (genvar f = 0; f < NUM_IN_FIELDS; f++) begin : g_unpack
    for (genvar i = 0; i < 3; i++) begin : g_coord
      assign pt[f][i] = in_tdata[f*FIELD_W + i*CW +: CW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s0_a[i]  <= pt[0][i];
        dir_a[i] <= DW'(pt[1][i]) - DW'(pt[0][i]);
        sv_a[i]  <= DW'(pt[0][i]) - DW'(pt[2][i]);
        eb_a[i]  <= DW'(pt[3][i]) - DW'(pt[2][i]);
        ec_a[i]  <= DW'(pt[4][i]) - DW'(pt[2][i]);
        ed_a[i]  <= DW'(pt[5][i]) - DW'(pt[2][i]);
      end
    end
  end

  // Both triangles run side by side; edge c - a is shared.
  logic          ok1, ok2;
  logic [NW-1:0] t1, t2, adet1, adet2;

  sqi_tri #(.DW(DW), .XW(XW), .PW(PW), .NW(NW), .THR(THR)) u_tri_abc (
    .clk(clk), .en(en), .e1(eb_a), .e2(ec_a), .dir(dir_a), .sv(sv_a),
    .ok(ok1), .t_o(t1), .adet_o(adet1)
  );

  sqi_tri #(.DW(DW), .XW(XW), .PW(PW), .NW(NW), .THR(THR)) u_tri_acd (
    .clk(clk), .en(en), .e1(ec_a), .e2(ed_a), .dir(dir_a), .sv(sv_a),
    .ok(ok2), .t_o(t2), .adet_o(adet2)
  );

  // s0 and the direction ride along with the triangle test.
  logic signed [CW-1:0] s0_t  [TRI_LAT][3];
  logic signed [DW-1:0] dir_t [TRI_LAT][3];

  always_ff @(posedge clk) begin
    if (en) begin
      s0_t[0]  <= s0_a;
      dir_t[0] <= dir_a;
      for (int k = 1; k < TRI_LAT; k++) begin
        s0_t[k]  <= s0_t[k-1];
        dir_t[k] <= dir_t[k-1];
      end
    end
  end

  // Select stage: the first triangle that is hit wins.
  logic                 hit_s;
  logic [NW-1:0]        t_s, den_s;
  logic [CW-1:0]        m_s [3];
  logic                 dneg_s [3];
  logic signed [CW-1:0] s0_s [3];

  always_ff @(posedge clk) begin
    if (en) begin
      hit_s <= ok1 || ok2;
      t_s   <= ok1 ? t1 : t2;
      den_s <= ok1 ? adet1 : adet2;
      for (int i = 0; i < 3; i++) begin
        dneg_s[i] <= dir_t[TRI_LAT-1][i][DW-1];
        m_s[i]    <= dir_t[TRI_LAT-1][i][DW-1] ? CW'(-dir_t[TRI_LAT-1][i])
                                               : CW'(dir_t[TRI_LAT-1][i]);
        s0_s[i]   <= s0_t[TRI_LAT-1][i];
      end
    end
  end

  // Scaled division, one unit per coordinate.
  logic [CW:0] q [3];

  for (genvar i = 0; i < 3; i++) begin : g_div
    sqi_div #(.MW(CW), .NW(NW)) u_div (
      .clk(clk), .en(en), .m(m_s[i]), .t(t_s), .den(den_s), .q(q[i])
    );
  end

  logic                 hit_d  [DL];
  logic                 dneg_d [DL][3];
  logic signed [CW-1:0] s0_d   [DL][3];

  always_ff @(posedge clk) begin
    if (en) begin
      hit_d[0]  <= hit_s;
      dneg_d[0] <= dneg_s;
      s0_d[0]   <= s0_s;
      for (int k = 1; k < DL; k++) begin
        hit_d[k]  <= hit_d[k-1];
        dneg_d[k] <= dneg_d[k-1];
        s0_d[k]   <= s0_d[k-1];
      end
    end
  end

  // Final add, clamp to the coordinate range, and zero on a miss.
  localparam logic signed [CW+1:0] LO = -((CW+2)'(1) <<< (CW-1));
  localparam logic signed [CW+1:0] HI = ((CW+2)'(1) <<< (CW-1)) - (CW+2)'(1);

  logic signed [CW+1:0]          val [3];
  logic signed [CW-1:0]          clp [3];
  logic signed [OUT_COORD_W-1:0] pnt [3];
  logic [OUT_TDATA_W-1:0]        out_nxt;
  logic [OUT_TDATA_W-1:0]        out_data_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      val[i] = dneg_d[DL-1][i] ? (CW+2)'(s0_d[DL-1][i]) - $signed({1'b0, q[i]})
                               : (CW+2)'(s0_d[DL-1][i]) + $signed({1'b0, q[i]});
      if (val[i] < LO) begin
        clp[i] = CW'(LO);
      end else if (val[i] > HI) begin
        clp[i] = CW'(HI);
      end else begin
        clp[i] = CW'(val[i]);
      end
      pnt[i] = hit_d[DL-1] ? OUT_COORD_W'(clp[i]) : '0;
    end
    out_nxt = {pnt[2], pnt[1], pnt[0], hit_d[DL-1]};
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A miss always reports the origin.
  `SQI_ASSERT_NOW(a_miss_zero, out_tvalid && !out_tdata[OUT_HIT_BIT], out_tdata[63:1] == '0)
  // A full last stage behind a stalled result holds intake.
  `SQI_ASSERT_NOW(a_hold, vld_r[L-1] && out_valid_r && !out_tready, !in_tready)
  // A taken result with nothing behind it empties the output register.
  `SQI_ASSERT_NEXT(a_drain, out_valid_r && out_tready && !vld_r[L-1], !out_valid_r)

endmodule

### tb/segment_quad_intersection_tb.sv
// ----------------------------------------------------------------------------
// Segment/quad intersection testbench
// Streams segment/quad requests into the block and checks every result against
// an exact fixed-point triangle test run in the bench, under varied handshakes.
// ----------------------------------------------------------------------------

// Holds the expected results of accepted requests in order of acceptance.
// Each expectation is computed when the request is accepted, using wide
// integer arithmetic so that no product or division loses a bit.
class hit_scoreboard;
  localparam longint COORD_MIN = -(64'sd1 <<< 20);
  localparam longint COORD_MAX = (64'sd1 <<< 20) - 1;

  logic [63:0] expected_q[$];
  int          hit_count;
  int          miss_count;

  function logic signed [127:0] dot3(longint a[3], longint b[3]);
    logic signed [127:0] x, y, acc;
    acc = 0;
    for (int i = 0; i < 3; i++) begin
      x = 128'(a[i]);
      y = 128'(b[i]);
      acc = acc + x * y;
    end
    return acc;
  endfunction

  // Tests one triangle; on a crossing, p receives the rounded, clamped point.
  function bit crosses_triangle(longint s0[3], longint s1[3], longint v0[3],
                                longint v1[3], longint v2[3], output longint p[3]);
    longint              e1[3], e2[3], dv[3], q[3], s[3], r[3];
    logic signed [127:0] det, adet, u, v, t;
    logic [191:0]        num, den, quo;
    longint              mag, step, val;
    bit                  neg;
    for (int i = 0; i < 3; i++) begin
      e1[i] = v1[i] - v0[i];
      e2[i] = v2[i] - v0[i];
      dv[i] = s1[i] - s0[i];
      s[i]  = s0[i] - v0[i];
      p[i]  = 0;
    end
    q[0] = dv[1] * e2[2] - dv[2] * e2[1];
    q[1] = dv[2] * e2[0] - dv[0] * e2[2];
    q[2] = dv[0] * e2[1] - dv[1] * e2[0];
    det = dot3(e1, q);
    neg = det < 0;
    adet = neg ? -det : det;
    // With 8 fraction bits a determinant below 2^-16 is below 256 raw units.
    if (adet < 256) return 0;
    r[0] = s[1] * e1[2] - s[2] * e1[1];
    r[1] = s[2] * e1[0] - s[0] * e1[2];
    r[2] = s[0] * e1[1] - s[1] * e1[0];
    u = dot3(s, q);
    v = dot3(dv, r);
    t = dot3(e2, r);
    if (neg) begin
      u = -u;
      v = -v;
      t = -t;
    end
    if (u < 0 || v < 0 || u + v > adet) return 0;
    if (t < 0 || t > adet) return 0;
    for (int i = 0; i < 3; i++) begin
      mag = dv[i] < 0 ? -dv[i] : dv[i];
      num = 192'(t);
      num = num * 192'(mag);
      den = 192'(adet);
      // Round to nearest, ties away from zero, on the magnitude.
      quo = (2 * num + den) / (2 * den);
      step = longint'(quo[63:0]);
      val = s0[i] + (dv[i] < 0 ? -step : step);
      p[i] = val < COORD_MIN ? COORD_MIN : (val > COORD_MAX ? COORD_MAX : val);
    end
    return 1;
  endfunction

  function void unpack_point(logic [62:0] w, output longint c[3]);
    for (int i = 0; i < 3; i++) c[i] = longint'($signed(w[21*i +: 21]));
  endfunction

  function void note_request(logic [383:0] data);
    longint pts[6][3];
    longint p[3];
    bit     hit;
    logic [63:0] word;
    for (int k = 0; k < 6; k++) unpack_point(data[63*k +: 63], pts[k]);
    hit = crosses_triangle(pts[0], pts[1], pts[2], pts[3], pts[4], p);
    if (!hit) hit = crosses_triangle(pts[0], pts[1], pts[2], pts[4], pts[5], p);
    if (!hit) p = '{0, 0, 0};
    if (hit) hit_count++;
    else miss_count++;
    word = {p[2][20:0], p[1][20:0], p[0][20:0], hit};
    expected_q.push_back(word);
  endfunction

  // Returns an empty string when the result matches the oldest expectation.
  function string check_result(logic [63:0] got);
    logic [63:0] want;
    string       msg;
    if (expected_q.size() == 0) return $sformatf("result %h with nothing expected", got);
    want = expected_q.pop_front();
    msg = "";
    if (got[0] != want[0]) msg = {msg, $sformatf(" hit %0b/%0b", got[0], want[0])};
    if (got[21:1] != want[21:1]) msg = {msg, $sformatf(" x %h/%h", got[21:1], want[21:1])};
    if (got[42:22] != want[42:22]) msg = {msg, $sformatf(" y %h/%h", got[42:22], want[42:22])};
    if (got[63:43] != want[63:43]) msg = {msg, $sformatf(" z %h/%h", got[63:43], want[63:43])};
    if (msg != "") msg = {"result mismatch (got/expected):", msg};
    return msg;
  endfunction
endclass

module segment_quad_intersection_tb;
  import sqi_pkg::*;

  // Pipeline depth is COORD_BITS + 8 for the default configuration.
  localparam int LATENCY = 29;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  hit_scoreboard sb;
  int            error_count;
  int            idle_pct;
  int            stall_pct;
  int            request_count;

  segment_quad_intersection i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task report(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    error_count++;
  endtask

  // Every accepted request gets its expectation at the same edge it is taken,
  // and every accepted result is checked against the oldest one.
  always @(posedge clk) begin
    string msg;
    if (rst_n && in_tvalid && in_tready) sb.note_request(in_tdata);
    if (rst_n && out_tvalid && out_tready) begin
      msg = sb.check_result(out_tdata);
      if (msg != "") report(msg);
    end
  end

  // The receiver stalls at random with the current phase's probability.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  function logic [62:0] pack_point(longint x, longint y, longint z);
    longint c[3];
    logic [62:0] w;
    c = '{x, y, z};
    for (int i = 0; i < 3; i++) begin
      if (c[i] < -(64'sd1 <<< 20)) c[i] = -(64'sd1 <<< 20);
      if (c[i] > (64'sd1 <<< 20) - 1) c[i] = (64'sd1 <<< 20) - 1;
      w[21*i +: 21] = c[i][20:0];
    end
    return w;
  endfunction

  function longint rnd_coord(int k);
    return longint'($urandom_range((1 << (k + 1)) - 1)) - (64'sd1 <<< k);
  endfunction

  function logic [62:0] rnd_field();
    return 63'({$urandom, $urandom});
  endfunction

  // Drives one request; the valid stays high into the next one unless a gap
  // is drawn, so back-to-back requests see no bubble.
  task send(input logic [62:0] s0, s1, a, b, c, d);
    @(negedge clk);
    if ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, d, c, b, a, s1, s0};
    do @(posedge clk); while (!in_tready);
    request_count++;
  endtask

  task pause_until_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // A quad around a random base, with the segment placed through a point
  // inside one of its triangles; the far end may stop on the plane or short.
  task send_crossing();
    longint base[3], cr[4][3], p[3], r[3], s0[3], s1[3];
    int     k, kd, tri_sel, w1, w2, w3, f;
    k       = $urandom_range(4, 18);
    kd      = $urandom_range(2, 17);
    tri_sel = $urandom_range(1);
    for (int i = 0; i < 3; i++) base[i] = rnd_coord(19);
    for (int j = 0; j < 4; j++)
      for (int i = 0; i < 3; i++) cr[j][i] = base[i] + rnd_coord(k);
    w1 = $urandom_range(15);
    w2 = $urandom_range(15);
    w3 = $urandom_range(1, 15);
    f  = $urandom_range(4);
    for (int i = 0; i < 3; i++) begin
      if (tri_sel == 0) p[i] = (w1 * cr[0][i] + w2 * cr[1][i] + w3 * cr[2][i]) / (w1 + w2 + w3);
      else p[i] = (w1 * cr[0][i] + w2 * cr[2][i] + w3 * cr[3][i]) / (w1 + w2 + w3);
      r[i]  = rnd_coord(kd);
      s0[i] = p[i] + r[i];
      // f of zero ends the segment at the crossing; four stops it short.
      s1[i] = (f == 4) ? p[i] + r[i] / 2 : p[i] - r[i] * (f - 1 > 0 ? f - 1 : 0);
    end
    send(pack_point(s0[0], s0[1], s0[2]), pack_point(s1[0], s1[1], s1[2]),
         pack_point(cr[0][0], cr[0][1], cr[0][2]), pack_point(cr[1][0], cr[1][1], cr[1][2]),
         pack_point(cr[2][0], cr[2][1], cr[2][2]), pack_point(cr[3][0], cr[3][1], cr[3][2]));
  endtask

  task send_directed();
    logic [62:0] ones, zero, pmax, pmin;
    int          u;
    ones = '1;
    zero = '0;
    pmax = pack_point(1048575, 1048575, 1048575);
    pmin = pack_point(-1048576, -1048576, -1048576);
    u = 256;
    // Unit quad in the z = 0 plane: a=(0,0), b=(4,0), c=(4,4), d=(0,4).
    // Crossing the first triangle.
    send(pack_point(3*u, u, 2*u), pack_point(3*u, u, -2*u), pack_point(0, 0, 0),
         pack_point(4*u, 0, 0), pack_point(4*u, 4*u, 0), pack_point(0, 4*u, 0));
    // Crossing the second triangle only.
    send(pack_point(u, 3*u, -u), pack_point(u, 3*u, u), pack_point(0, 0, 0),
         pack_point(4*u, 0, 0), pack_point(4*u, 4*u, 0), pack_point(0, 4*u, 0));
    // Missing the quad beside it.
    send(pack_point(9*u, u, 2*u), pack_point(9*u, u, -2*u), pack_point(0, 0, 0),
         pack_point(4*u, 0, 0), pack_point(4*u, 4*u, 0), pack_point(0, 4*u, 0));
    // Segment ending on the plane, and segment stopping before it.
    send(pack_point(u, u / 2, 2*u), pack_point(u, u / 2, 0), pack_point(0, 0, 0),
         pack_point(4*u, 0, 0), pack_point(4*u, 4*u, 0), pack_point(0, 4*u, 0));
    send(pack_point(u, u / 2, 2*u), pack_point(u, u / 2, 1), pack_point(0, 0, 0),
         pack_point(4*u, 0, 0), pack_point(4*u, 4*u, 0), pack_point(0, 4*u, 0));
    // Segment parallel to the plane, degenerate quad, tiny determinant.
    send(pack_point(u, u, 0), pack_point(3*u, u, 0), pack_point(0, 0, 0),
         pack_point(4*u, 0, 0), pack_point(4*u, 4*u, 0), pack_point(0, 4*u, 0));
    send(pack_point(u, u, u), pack_point(u, u, -u), pack_point(0, 0, 0),
         pack_point(u, u, 0), pack_point(2*u, 2*u, 0), pack_point(3*u, 3*u, 0));
    send(pack_point(0, 0, 1), pack_point(0, 0, -1), pack_point(-2, -2, 0),
         pack_point(4, -2, 0), pack_point(4, 4, 0), pack_point(-2, 4, 0));
    send(pack_point(0, 0, 8), pack_point(0, 0, -8), pack_point(-8, -8, 0),
         pack_point(8, -8, 0), pack_point(8, 8, 0), pack_point(-8, 8, 0));
    // Crossing exactly on the shared diagonal and on a corner.
    send(pack_point(2*u, 2*u, u), pack_point(2*u, 2*u, -u), pack_point(0, 0, 0),
         pack_point(4*u, 0, 0), pack_point(4*u, 4*u, 0), pack_point(0, 4*u, 0));
    send(pack_point(0, 0, u), pack_point(0, 0, -u), pack_point(0, 0, 0),
         pack_point(4*u, 0, 0), pack_point(4*u, 4*u, 0), pack_point(0, 4*u, 0));
    // Coordinate extremes: huge quad crossed at full-range spans.
    send(pmin, pmax, pack_point(1048575, -1048576, 0), pack_point(-1048576, -1048576, 0),
         pack_point(-1048576, 1048575, 0), pack_point(1048575, 1048575, 0));
    send(pack_point(1048575, 0, 1048575), pack_point(-1048576, 0, -1048576),
         pmin, pack_point(1048575, -1048576, -1048576), pmax,
         pack_point(-1048576, 1048575, 1048575));
    send(ones, zero, ones, zero, ones, zero);
    send(zero, zero, zero, zero, zero, zero);
    send(ones, ones, ones, ones, ones, ones);
    send(pmax, pmin, pmin, pmax, pmin, pmax);
  endtask

  initial begin
    sb = new();
    error_count   = 0;
    request_count = 0;
    idle_pct  = 0;
    stall_pct = 0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    send_directed();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 56; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 56; end
        default: begin idle_pct = 29; stall_pct = 29; end
      endcase
      for (int n = 0; n < 310; n++) begin
        int pick;
        pick = $urandom_range(99);
        if (pick < 70) send_crossing();
        else if (pick < 90)
          send(rnd_field(), rnd_field(), rnd_field(), rnd_field(), rnd_field(), rnd_field());
        else send(rnd_field(), rnd_field(), rnd_field(), rnd_field(), rnd_field(),
                  pack_point(0, 0, 0));
        if (ph == 1 && n == 150) pause_until_drained();
      end
    end
    pause_until_drained();

    $display("Sent %0d segment/quad requests: %0d predicted crossings, %0d misses,",
             request_count, sb.hit_count, sb.miss_count);
    $display("over four handshake mixes with random sender gaps and receiver stalls.");
    if (sb.expected_q.size() != 0)
      report($sformatf("%0d results never arrived", sb.expected_q.size()));
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
